FILE: rtl/core/tpi_pkg.sv
// Shared types and constants for the triangle/plane slicer.
// No dependencies; every other file in rtl/core imports this package.
package tpi_pkg;

  // Coordinate format of the ports (two's complement).
  localparam int COORD_WIDTH = 32;
  // Magnitude of a plane-relative difference.
  localparam int MAG_W = COORD_WIDTH + 1;
  // Magnitude of a height difference between two vertices.
  localparam int DIV_W = COORD_WIDTH + 2;
  // Interpolator latency: product register, one register per quotient bit, sum register.
  localparam int LANE_LAT = MAG_W + 2;
  // Default depth of the queue between classifier and interpolators.
  localparam int TPI_QUEUE_DEPTH = 4;

  // Result kinds.
  localparam logic [1:0] HIT_NONE   = 2'd0;
  localparam logic [1:0] HIT_CROSS  = 2'd1;
  localparam logic [1:0] HIT_EDGE   = 2'd2;
  localparam logic [1:0] HIT_VERTEX = 2'd3;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_a_x;
    logic signed [COORD_WIDTH-1:0] vertex_a_y;
    logic signed [COORD_WIDTH-1:0] vertex_a_z;
    logic signed [COORD_WIDTH-1:0] vertex_b_x;
    logic signed [COORD_WIDTH-1:0] vertex_b_y;
    logic signed [COORD_WIDTH-1:0] vertex_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_c_x;
    logic signed [COORD_WIDTH-1:0] vertex_c_y;
    logic signed [COORD_WIDTH-1:0] vertex_c_z;
    logic signed [COORD_WIDTH-1:0] plane_height;
  } tri_in_t;

  typedef struct packed {
    logic [1:0]                    hit_kind;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
  } seg_out_t;

  // One coordinate job: base + sign * trunc(a * b / d).
  typedef struct packed {
    logic [COORD_WIDTH-1:0] base;
    logic [MAG_W-1:0]       mag_b;
    logic                   neg;
  } coord_job_t;

  // One segment end: both coordinates share the height terms.
  typedef struct packed {
    logic [MAG_W-1:0] mag_a;
    logic [DIV_W-1:0] mag_d;
    coord_job_t       cx;
    coord_job_t       cy;
  } point_job_t;

  // Classified triangle as it waits in the queue.
  typedef struct packed {
    logic [1:0] hit_kind;
    point_job_t p0;
    point_job_t p1;
  } tri_job_t;

endpackage

FILE: rtl/core/tpi_front.sv
// Classifier: sorts vertices against the plane and sets up the interpolation jobs.
// Depends on tpi_pkg.
module tpi_front import tpi_pkg::*; (
  input  tri_in_t  tri_in,
  output tri_job_t job
);

  localparam int W = COORD_WIDTH;

  // Crossing point setup on edge (i, j).
  function automatic point_job_t edge_job(input logic signed [W-1:0] xi, input logic signed [W-1:0] yi,
                                          input logic signed [W:0] zi, input logic signed [W-1:0] xj,
                                          input logic signed [W-1:0] yj, input logic signed [W:0] zj);
    point_job_t          p;
    logic signed [W:0]   dx;
    logic signed [W:0]   dy;
    logic signed [W+1:0] dz;
    dx = {xj[W-1], xj} - {xi[W-1], xi};
    dy = {yj[W-1], yj} - {yi[W-1], yi};
    dz = {zi[W], zi} - {zj[W], zj};
    p.mag_a    = zi[W] ? MAG_W'(-zi) : MAG_W'(zi);
    p.mag_d    = dz[W+1] ? DIV_W'(-dz) : DIV_W'(dz);
    p.cx.base  = xi;
    p.cx.mag_b = dx[W] ? MAG_W'(-dx) : MAG_W'(dx);
    p.cx.neg   = dx[W];
    p.cy.base  = yi;
    p.cy.mag_b = dy[W] ? MAG_W'(-dy) : MAG_W'(dy);
    p.cy.neg   = dy[W];
    return p;
  endfunction

  // A vertex passes through unchanged: a zero product over a unit divisor.
  function automatic point_job_t vert_job(input logic signed [W-1:0] xv,
                                          input logic signed [W-1:0] yv);
    point_job_t p;
    p          = '0;
    p.mag_d    = DIV_W'(1);
    p.cx.base  = xv;
    p.cy.base  = yv;
    return p;
  endfunction

  logic signed [W-1:0] x [3];
  logic signed [W-1:0] y [3];
  logic signed [W:0]   z [3];
  logic [2:0]          sz;
  logic [2:0]          sp;
  logic [1:0]          n_zero;
  point_job_t          e0, e1, e2, none;
  logic                c0, c1, c2;

  // Heights relative to the plane and their signs.
  always_comb begin
    x[0] = tri_in.vertex_a_x;  y[0] = tri_in.vertex_a_y;
    x[1] = tri_in.vertex_b_x;  y[1] = tri_in.vertex_b_y;
    x[2] = tri_in.vertex_c_x;  y[2] = tri_in.vertex_c_y;
    z[0] = {tri_in.vertex_a_z[W-1], tri_in.vertex_a_z} - {tri_in.plane_height[W-1], tri_in.plane_height};
    z[1] = {tri_in.vertex_b_z[W-1], tri_in.vertex_b_z} - {tri_in.plane_height[W-1], tri_in.plane_height};
    z[2] = {tri_in.vertex_c_z[W-1], tri_in.vertex_c_z} - {tri_in.plane_height[W-1], tri_in.plane_height};
    for (int k = 0; k < 3; k++) begin
      sz[k] = (z[k] == '0);
      sp[k] = !z[k][W] && !sz[k];
    end
    n_zero = 2'({1'b0, sz[0]} + {1'b0, sz[1]} + {1'b0, sz[2]});
  end

  // Edge jobs in the order (a,c), (b,a), (c,b).
  always_comb begin
    e0   = edge_job(x[0], y[0], z[0], x[2], y[2], z[2]);
    e1   = edge_job(x[1], y[1], z[1], x[0], y[0], z[0]);
    e2   = edge_job(x[2], y[2], z[2], x[1], y[1], z[1]);
    none = vert_job('0, '0);
    c0   = sp[0] != sp[2];
    c1   = sp[1] != sp[0];
    c2   = sp[2] != sp[1];
  end

  // Case selection.
  always_comb begin
    job.hit_kind = HIT_NONE;
    job.p0       = none;
    job.p1       = none;
    case (n_zero)
      2'd0: begin
        if (c0 || c1 || c2) begin
          job.hit_kind = HIT_CROSS;
          job.p0       = c0 ? e0 : e1;
          job.p1       = (c0 && c1) ? e1 : e2;
        end
      end
      2'd1: begin
        // Vertex on the plane: the opposite edge must straddle it.
        if (sz[0] && c2) begin
          job.hit_kind = HIT_VERTEX;
          job.p0       = vert_job(x[0], y[0]);
          job.p1       = edge_job(x[2], y[2], z[2], x[1], y[1], z[1]);
        end else if (sz[1] && c0) begin
          job.hit_kind = HIT_VERTEX;
          job.p0       = vert_job(x[1], y[1]);
          job.p1       = edge_job(x[0], y[0], z[0], x[2], y[2], z[2]);
        end else if (sz[2] && c1) begin
          job.hit_kind = HIT_VERTEX;
          job.p0       = vert_job(x[2], y[2]);
          job.p1       = edge_job(x[1], y[1], z[1], x[0], y[0], z[0]);
        end
      end
      2'd2: begin
        job.hit_kind = HIT_EDGE;
        if (sz[0]) begin
          job.p0 = vert_job(x[0], y[0]);
          job.p1 = sz[1] ? vert_job(x[1], y[1]) : vert_job(x[2], y[2]);
        end else begin
          job.p0 = vert_job(x[1], y[1]);
          job.p1 = vert_job(x[2], y[2]);
        end
      end
      default: begin
        job.hit_kind = HIT_NONE;
      end
    endcase
  end

endmodule

FILE: rtl/core/tpi_queue.sv
// Short queue of classified triangles between classifier and interpolators.
// Depends on tpi_pkg.
module tpi_queue import tpi_pkg::*; #(
  parameter int DEPTH = TPI_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  tri_job_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output tri_job_t rd_data,
  output logic     empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  tri_job_t        entries [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // Storage, written on an input transfer.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/tpi_lerp.sv
// Pipelined interpolator lane: base +/- trunc(a * b / d), one quotient bit per stage.
// Depends on tpi_pkg.
module tpi_lerp import tpi_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [MAG_W-1:0]       mag_a,
  input  logic [DIV_W-1:0]       mag_d,
  input  coord_job_t             job,
  output logic [COORD_WIDTH-1:0] result
);

  localparam int N = MAG_W;

  // Product stage.
  logic [2*N-1:0]         prod;
  logic [N:0]             div_m;
  logic [COORD_WIDTH-1:0] base_m;
  logic                   neg_m;

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= mag_a * job.mag_b;
      div_m  <= mag_d;
      base_m <= job.base;
      neg_m  <= job.neg;
    end
  end

  // Division stages; the quotient never exceeds b, so the high half is below d.
  logic [N:0]             rem  [N];
  logic [N-1:0]           low  [N];
  logic [N-1:0]           quo  [N];
  logic [N:0]             dvs  [N];
  logic [COORD_WIDTH-1:0] base [N];
  logic                   neg  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [N:0]             r_in;
    logic [N-1:0]           l_in;
    logic [N-1:0]           q_in;
    logic [N:0]             d_in;
    logic [COORD_WIDTH-1:0] b_in;
    logic                   n_in;
    logic [N+1:0]           trial;
    logic                   ge;

    if (k == 0) begin : g_first
      assign r_in = {1'b0, prod[2*N-1:N]};
      assign l_in = prod[N-1:0];
      assign q_in = '0;
      assign d_in = div_m;
      assign b_in = base_m;
      assign n_in = neg_m;
    end else begin : g_next
      assign r_in = rem[k-1];
      assign l_in = low[k-1];
      assign q_in = quo[k-1];
      assign d_in = dvs[k-1];
      assign b_in = base[k-1];
      assign n_in = neg[k-1];
    end

    assign trial = {r_in, l_in[N-1]};
    assign ge    = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? (N+1)'(trial - {1'b0, d_in}) : (N+1)'(trial);
        low[k]  <= {l_in[N-2:0], 1'b0};
        quo[k]  <= {q_in[N-2:0], ge};
        dvs[k]  <= d_in;
        base[k] <= b_in;
        neg[k]  <= n_in;
      end
    end
  end

  // Final sum; the point lies on the edge, so the low bits are exact.
  logic [N-1:0] base_ext;
  assign base_ext = {base[N-1][COORD_WIDTH-1], base[N-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      result <= neg[N-1] ? COORD_WIDTH'(base_ext - quo[N-1])
                         : COORD_WIDTH'(base_ext + quo[N-1]);
    end
  end

endmodule

FILE: rtl/core/tpi_back.sv
// Execution side: four interpolator lanes and the valid and kind pipe alongside them.
// Depends on tpi_pkg and tpi_lerp.
module tpi_back import tpi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  tri_job_t job,
  input  logic     job_empty,
  output logic     job_take,
  output seg_out_t segment,
  output logic     empty,
  input  logic     pop
);

  localparam int L = LANE_LAT;

  logic                   adv;
  logic                   vld  [L];
  logic [1:0]             kind [L];
  logic [COORD_WIDTH-1:0] lane_start_x;
  logic [COORD_WIDTH-1:0] lane_start_y;
  logic [COORD_WIDTH-1:0] lane_end_x;
  logic [COORD_WIDTH-1:0] lane_end_y;

  // The whole pipe moves unless a finished result is waiting unread.
  assign adv      = !vld[L-1] || pop;
  assign job_take = adv && !job_empty;
  assign empty    = !vld[L-1];

  // Valid and kind travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < L; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= !job_empty;
      for (int k = 1; k < L; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind[0] <= job.hit_kind;
      for (int k = 1; k < L; k++) begin
        kind[k] <= kind[k-1];
      end
    end
  end

  // The result is gathered from the kind pipe and the four lanes.
  assign segment = {kind[L-1], lane_start_x, lane_start_y, lane_end_x, lane_end_y};

  tpi_lerp u_start_x (.clk(clk), .en(adv), .mag_a(job.p0.mag_a), .mag_d(job.p0.mag_d),
                      .job(job.p0.cx), .result(lane_start_x));
  tpi_lerp u_start_y (.clk(clk), .en(adv), .mag_a(job.p0.mag_a), .mag_d(job.p0.mag_d),
                      .job(job.p0.cy), .result(lane_start_y));
  tpi_lerp u_end_x   (.clk(clk), .en(adv), .mag_a(job.p1.mag_a), .mag_d(job.p1.mag_d),
                      .job(job.p1.cx), .result(lane_end_x));
  tpi_lerp u_end_y   (.clk(clk), .en(adv), .mag_a(job.p1.mag_a), .mag_d(job.p1.mag_d),
                      .job(job.p1.cy), .result(lane_end_y));

endmodule

FILE: rtl/core/triangle_plane_intersect.sv
// Triangle/plane slicer top level: classifier, job queue and interpolator pipe.
// Depends on tpi_pkg, tpi_front, tpi_queue, tpi_back.
//
// Input channel: a triangle and plane height transfer when push is high and
// full is low. Result channel: the oldest segment sits on segment while empty
// is low and transfers when pop is high. One segment comes out per triangle,
// in order.
// A triangle is classified in its accept cycle and queued; from the queue it
// passes the product register, one register per quotient bit of the
// COORD_WIDTH + 1 bit pipelined dividers, and the sum register.
// Throughput: one triangle per cycle unless the receiver stalls, set by the
// fully pipelined divider lanes. When the receiver stalls, the interpolator
// pipe holds, the queue fills, and full rises once QUEUE_DEPTH triangles
// wait. Reset clears the queue and the pipe valids: full is low and empty
// high after reset.
module triangle_plane_intersect import tpi_pkg::*; #(
  parameter int QUEUE_DEPTH = TPI_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  tri_in_t  triangle,
  output logic     empty,
  input  logic     pop,
  output seg_out_t segment
);

  tri_job_t front_job;
  tri_job_t queue_job;
  logic     queue_empty;
  logic     queue_take;

  tpi_front u_front (.tri_in(triangle), .job(front_job));

  tpi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .wr_en(push && !full), .wr_data(front_job), .full(full),
    .rd_en(queue_take), .rd_data(queue_job), .empty(queue_empty)
  );

  tpi_back u_back (
    .clk(clk), .rst(rst),
    .job(queue_job), .job_empty(queue_empty), .job_take(queue_take),
    .segment(segment), .empty(empty), .pop(pop)
  );

  // After reset nothing is queued and no result is shown.
  a_reset_idle: assert property (@(posedge clk) rst |=> !full && empty)
    else $error("block not idle after reset");

  // A result with no segment carries zero coordinates.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && segment.hit_kind == HIT_NONE) |->
      (segment.start_x == '0 && segment.start_y == '0 &&
       segment.end_x == '0 && segment.end_y == '0))
    else $error("no-segment result with nonzero coordinates");

  // The queue is drained only when it holds something.
  a_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    queue_take |-> !queue_empty)
    else $error("job taken from an empty queue");

endmodule
